/* rtl/usm_pkg.sv */
// ----------------------------------------------------------------------------
// usm_pkg
// Shared types, register indexes and gain curves of the 3x3 unsharp-mask
// luma sharpener.
// ----------------------------------------------------------------------------
package usm_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_FRAME_WIDTH   = 2'd0;
  localparam logic [1:0] CFG_FRAME_HEIGHT  = 2'd1;
  localparam logic [1:0] CFG_GLOBAL_WEIGHT = 2'd2;
  localparam logic [1:0] CFG_CURVE_SELECT  = 2'd3;

  localparam int CFG_DATA_W = 12;

  // reset values of the configuration registers
  localparam logic [10:0] FRAME_WIDTH_RST   = 11'd640;
  localparam logic [11:0] FRAME_HEIGHT_RST  = 12'd480;
  localparam logic [7:0]  GLOBAL_WEIGHT_RST = 8'd8;
  localparam logic [2:0]  CURVE_SELECT_RST  = 3'd0;

  localparam logic [2:0] CURVE_LAST = 3'd5;
  localparam logic [6:0] EDGE_MAX   = 7'd127;
  localparam logic [6:0] CURVE_SAT  = 7'd127;
  localparam int         SHARP_SHIFT = 4;
  localparam int         BOOST_SHIFT = 8 + 3;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_UPD,
    S_CALC,
    S_MUL,
    S_DONE
  } usm_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic rd_en;
    logic upd_en;
    logic calc_en;
    logic mul_en;
    logic load_en;
  } usm_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic produce;
    logic out_valid;
  } usm_sts_t;

  // gain curve prefixes, entries past each prefix saturate
  localparam logic [6:0] CURVE0 [16] = '{
    7'd0, 7'd8, 7'd16, 7'd24, 7'd32, 7'd40, 7'd48, 7'd56, 7'd64, 7'd72, 7'd80,
    7'd88, 7'd96, 7'd104, 7'd112, 7'd120};
  localparam logic [6:0] CURVE1 [22] = '{
    7'd0, 7'd1, 7'd1, 7'd2, 7'd2, 7'd3, 7'd3, 7'd4, 7'd12, 7'd21, 7'd29, 7'd38,
    7'd46, 7'd55, 7'd63, 7'd72, 7'd80, 7'd89, 7'd97, 7'd106, 7'd114, 7'd123};
  localparam logic [6:0] CURVE2 [18] = '{
    7'd0, 7'd2, 7'd4, 7'd6, 7'd15, 7'd23, 7'd32, 7'd40, 7'd49, 7'd57, 7'd66,
    7'd74, 7'd83, 7'd91, 7'd100, 7'd108, 7'd117, 7'd125};
  localparam logic [6:0] CURVE3 [64] = '{
    7'd0, 7'd2, 7'd4, 7'd6, 7'd8, 7'd10, 7'd12, 7'd14, 7'd16, 7'd18, 7'd20,
    7'd22, 7'd24, 7'd26, 7'd28, 7'd30, 7'd32, 7'd34, 7'd36, 7'd38, 7'd40, 7'd42,
    7'd44, 7'd46, 7'd48, 7'd50, 7'd52, 7'd54, 7'd56, 7'd58, 7'd60, 7'd62, 7'd64,
    7'd66, 7'd68, 7'd70, 7'd72, 7'd74, 7'd76, 7'd78, 7'd80, 7'd82, 7'd84, 7'd86,
    7'd88, 7'd90, 7'd92, 7'd94, 7'd96, 7'd98, 7'd100, 7'd102, 7'd104, 7'd106,
    7'd108, 7'd110, 7'd112, 7'd114, 7'd116, 7'd118, 7'd120, 7'd122, 7'd124,
    7'd126};
  localparam logic [6:0] CURVE4 [53] = '{
    7'd0, 7'd1, 7'd1, 7'd2, 7'd4, 7'd7, 7'd9, 7'd12, 7'd14, 7'd17, 7'd19, 7'd22,
    7'd24, 7'd27, 7'd29, 7'd32, 7'd34, 7'd37, 7'd39, 7'd42, 7'd44, 7'd47, 7'd49,
    7'd52, 7'd54, 7'd57, 7'd59, 7'd62, 7'd64, 7'd67, 7'd69, 7'd72, 7'd74, 7'd77,
    7'd79, 7'd82, 7'd84, 7'd87, 7'd89, 7'd92, 7'd94, 7'd97, 7'd99, 7'd102,
    7'd104, 7'd107, 7'd109, 7'd112, 7'd114, 7'd117, 7'd119, 7'd122, 7'd124};
  localparam logic [6:0] CURVE5 [67] = '{
    7'd0, 7'd1, 7'd1, 7'd2, 7'd2, 7'd3, 7'd5, 7'd7, 7'd9, 7'd11, 7'd13, 7'd15,
    7'd17, 7'd19, 7'd21, 7'd23, 7'd25, 7'd27, 7'd29, 7'd31, 7'd33, 7'd35, 7'd37,
    7'd39, 7'd41, 7'd43, 7'd45, 7'd47, 7'd49, 7'd51, 7'd53, 7'd55, 7'd57, 7'd59,
    7'd61, 7'd63, 7'd65, 7'd67, 7'd69, 7'd71, 7'd73, 7'd75, 7'd77, 7'd79, 7'd81,
    7'd83, 7'd85, 7'd87, 7'd89, 7'd91, 7'd93, 7'd95, 7'd97, 7'd99, 7'd101,
    7'd103, 7'd105, 7'd107, 7'd109, 7'd111, 7'd113, 7'd115, 7'd117, 7'd119,
    7'd121, 7'd123, 7'd125};

  // boost value for an edge strength on one curve
  function automatic logic [6:0] curve_value(input logic [2:0] sel, input logic [6:0] d);
    logic [6:0] v;
    v = CURVE_SAT;
    case (sel)
      3'd0:    if (d < 7'd16) v = CURVE0[d[3:0]];
      3'd1:    if (d < 7'd22) v = CURVE1[d[4:0]];
      3'd2:    if (d < 7'd18) v = CURVE2[d[4:0]];
      3'd3:    if (d < 7'd64) v = CURVE3[d[5:0]];
      3'd4:    if (d < 7'd53) v = CURVE4[d[5:0]];
      default: if (d < 7'd67) v = CURVE5[d];
    endcase
    return v;
  endfunction

endpackage

/* rtl/usm_ram.sv */
// ----------------------------------------------------------------------------
// usm_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module usm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/usm_ctrl.sv */
// ----------------------------------------------------------------------------
// usm_ctrl
// Per-pixel sequencer: read line stores, update window, filter, multiply,
// load the output register.
// ----------------------------------------------------------------------------
module usm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_ready,
  input  usm_pkg::usm_sts_t sts,
  output usm_pkg::usm_cmd_t cmd
);
  import usm_pkg::*;

  usm_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.rd_en = 1'b1;
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        cmd.upd_en = 1'b1;
        state_nxt  = S_CALC;
      end
      S_CALC: begin
        cmd.calc_en = 1'b1;
        state_nxt   = S_MUL;
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        // border pixels finish without a result
        if (!sts.produce) begin
          state_nxt = S_IDLE;
        end else if (!sts.out_valid || out_ready) begin
          cmd.load_en = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // an accepted pixel always updates the window next cycle
  a_accept_upd: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> cmd.upd_en)
    else $error("window update did not follow a pixel transfer");

  // the filter step follows the update step
  a_upd_calc: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd_en |=> cmd.calc_en)
    else $error("filter step did not follow window update");

  // never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_en |-> !sts.out_valid || out_ready)
    else $error("output register loaded while a result was stalled");

endmodule

/* rtl/usm_datapath.sv */
// ----------------------------------------------------------------------------
// usm_datapath
// Line stores, 3x3 luma window, high-pass filter, gain curve, boost
// multiply, clamp and output register.
// ----------------------------------------------------------------------------
module usm_datapath #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  usm_pkg::usm_cmd_t             cmd,
  output usm_pkg::usm_sts_t             sts,
  input  logic                          cfg_valid,
  input  logic [1:0]                    cfg_index,
  input  logic [usm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [7:0]                    in_luma,
  input  logic [7:0]                    in_chroma,
  input  logic [4:0]                    in_pixel_weight,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [7:0]                    out_luma,
  output logic [7:0]                    out_chroma,
  output logic                          out_last_of_frame
);
  import usm_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam logic [12:0] MAXW = 13'(MAX_WIDTH);

  // configuration registers
  logic [10:0] frame_width_r;
  logic [11:0] frame_height_r;
  logic [7:0]  global_weight_r;
  logic [2:0]  curve_select_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r   <= FRAME_WIDTH_RST;
      frame_height_r  <= FRAME_HEIGHT_RST;
      global_weight_r <= GLOBAL_WEIGHT_RST;
      curve_select_r  <= CURVE_SELECT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:   frame_width_r   <= cfg_data[10:0];
        CFG_FRAME_HEIGHT:  frame_height_r  <= cfg_data[11:0];
        CFG_GLOBAL_WEIGHT: global_weight_r <= cfg_data[7:0];
        CFG_CURVE_SELECT:  curve_select_r  <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // effective geometry and curve
  logic [12:0] w13, w_eff, h_eff;
  logic [2:0]  sel_eff;

  always_comb begin
    w13 = 13'(frame_width_r);
    if (w13 < 13'd3) begin
      w_eff = 13'd3;
    end else if (w13 > MAXW) begin
      w_eff = MAXW;
    end else begin
      w_eff = w13;
    end
    h_eff   = (frame_height_r < 12'd3) ? 13'd3 : 13'(frame_height_r);
    sel_eff = (curve_select_r > CURVE_LAST) ? CURVE_LAST : curve_select_r;
  end

  // input capture
  logic [7:0] lu_r, ch_r;
  logic [4:0] pw_r;

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      lu_r <= in_luma;
      ch_r <= in_chroma;
      pw_r <= in_pixel_weight;
    end
  end

  // position counters
  logic [10:0] col_r, col_nxt;
  logic [11:0] row_r, row_nxt;
  logic [12:0] col13, row13;
  logic [AW-1:0] idx;

  assign col13 = 13'(col_r);
  assign row13 = 13'(row_r);
  assign idx   = col13[AW-1:0];

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (col13 + 13'd1 >= w_eff) begin
      col_nxt = '0;
      row_nxt = (row13 + 13'd1 >= h_eff) ? '0 : row_r + 12'd1;
    end else begin
      col_nxt = col_r + 11'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cmd.upd_en) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // line stores: newest line, older line, and {weight, chroma}
  logic [7:0]  line0_rd, line1_rd;
  logic [12:0] aux_rd;

  usm_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_line0 (
    .clk   (clk),
    .we    (cmd.upd_en),
    .waddr (idx),
    .wdata (lu_r),
    .re    (cmd.rd_en),
    .raddr (idx),
    .rdata (line0_rd)
  );

  usm_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_line1 (
    .clk   (clk),
    .we    (cmd.upd_en),
    .waddr (idx),
    .wdata (line0_rd),
    .re    (cmd.rd_en),
    .raddr (idx),
    .rdata (line1_rd)
  );

  usm_ram #(.WIDTH(13), .DEPTH(MAX_WIDTH)) u_aux (
    .clk   (clk),
    .we    (cmd.upd_en),
    .waddr (idx),
    .wdata ({pw_r, ch_r}),
    .re    (cmd.rd_en),
    .raddr (idx),
    .rdata (aux_rd)
  );

  // window shift and centre aux delay
  logic [7:0]  win_r [9];
  logic [12:0] hold_r [2];
  logic        produce_r, last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
      hold_r[0] <= '0;
      hold_r[1] <= '0;
      produce_r <= 1'b0;
      last_r    <= 1'b0;
    end else if (cmd.upd_en) begin
      for (int k = 0; k < 3; k++) begin
        win_r[k*3+0] <= win_r[k*3+1];
        win_r[k*3+1] <= win_r[k*3+2];
      end
      win_r[2]  <= line1_rd;
      win_r[5]  <= line0_rd;
      win_r[8]  <= lu_r;
      hold_r[0] <= aux_rd;
      hold_r[1] <= hold_r[0];
      produce_r <= (row_r >= 12'd2) && (col_r >= 11'd2);
      last_r    <= (row13 >= h_eff - 13'd1) && (col13 >= w_eff - 13'd1);
    end
  end

  // high-pass sum and edge strength
  logic [9:0]  corners, edges;
  logic [13:0] sum, mag;
  logic [9:0]  mag4;
  logic [6:0]  strength;

  always_comb begin
    corners  = 10'(win_r[0]) + 10'(win_r[2]) + 10'(win_r[6]) + 10'(win_r[8]);
    edges    = 10'(win_r[1]) + 10'(win_r[3]) + 10'(win_r[5]) + 10'(win_r[7]);
    sum      = 14'(win_r[4]) * 14'd12 - 14'(corners) - (14'(edges) << 1);
    mag      = sum[13] ? -sum : sum;
    mag4     = mag[SHARP_SHIFT +: 10];
    strength = (mag4 > 10'(EDGE_MAX)) ? EDGE_MAX : mag4[6:0];
  end

  // filter step and first multiply step registers
  logic       neg_r;
  logic [7:0] centre_r, cc_r;
  logic [4:0] cw_r;
  logic [6:0] cv_r;
  logic [11:0] p1_r;

  always_ff @(posedge clk) begin
    if (cmd.calc_en) begin
      neg_r    <= sum[13];
      centre_r <= win_r[4];
      cw_r     <= hold_r[1][12:8];
      cc_r     <= hold_r[1][7:0];
      cv_r     <= curve_value(sel_eff, strength);
    end
    if (cmd.mul_en) begin
      p1_r <= 12'(cv_r) * 12'(cw_r);
    end
  end

  // boost, apply and clamp
  logic [19:0] prod;
  logic [8:0]  boost;
  logic [10:0] px;
  logic [7:0]  px_clamp;

  always_comb begin
    prod  = 20'(p1_r) * 20'(global_weight_r);
    boost = prod[BOOST_SHIFT +: 9];
    px    = neg_r ? 11'(centre_r) - 11'(boost) : 11'(centre_r) + 11'(boost);
    if (px[10]) begin
      px_clamp = 8'd0;
    end else if (px > 11'd255) begin
      px_clamp = 8'd255;
    end else begin
      px_clamp = px[7:0];
    end
  end

  // output register
  logic       out_valid_r;
  logic [7:0] out_luma_r, out_chroma_r;
  logic       out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_en) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_en) begin
      out_luma_r   <= px_clamp;
      out_chroma_r <= cc_r;
      out_last_r   <= last_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_luma          = out_luma_r;
  assign out_chroma        = out_chroma_r;
  assign out_last_of_frame = out_last_r;

  assign sts.produce   = produce_r;
  assign sts.out_valid = out_valid_r;

  // only interior pixels give a result
  a_load_interior: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_en |-> produce_r)
    else $error("result loaded for a border pixel");

endmodule

/* rtl/unsharp_mask_sharpen_3x3_top.sv */
// ----------------------------------------------------------------------------
// unsharp_mask_sharpen_3x3_top
// 3x3 unsharp-mask luma sharpener for a raster YUYV pixel stream.
//
//   channel  direction  handshake             payload
//   in       input      in_valid/in_ready     in_luma, in_chroma, in_pixel_weight
//   out      output     out_valid/out_ready   out_luma, out_chroma, out_last_of_frame
//   cfg      input      cfg_valid/cfg_ready   cfg_index, cfg_data
//
// Each pixel goes through one line-store read, window update with
// line-store write, filter and curve lookup, and two multiply steps.
// A result waits in the output register while the next pixel is worked on;
// the final step stalls only when that register is still full.
// Reset is synchronous, active low; line stores need no clearing pass.
// Configuration writes are taken in any cycle.
// ----------------------------------------------------------------------------
module unsharp_mask_sharpen_3x3_top #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_luma,
  input  logic [7:0]                     in_chroma,
  input  logic [4:0]                     in_pixel_weight,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_luma,
  output logic [7:0]                     out_chroma,
  output logic                           out_last_of_frame,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [1:0]                     cfg_index,
  input  logic [usm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import usm_pkg::*;

  usm_cmd_t cmd;
  usm_sts_t sts;

  assign cfg_ready = 1'b1;

  // sequencer
  usm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath
  usm_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_luma           (in_luma),
    .in_chroma         (in_chroma),
    .in_pixel_weight   (in_pixel_weight),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_luma          (out_luma),
    .out_chroma        (out_chroma),
    .out_last_of_frame (out_last_of_frame)
  );

endmodule
